// ===== rtl/pcf_pkg.sv =====
// shared constants for the phase code coefficient fuse pipeline
package pcf_pkg;

   localparam int unsigned FLOAT_W  = 32;
   localparam int unsigned HALF_W   = 16;
   localparam int unsigned CODE_W   = 2;
   localparam int unsigned ADD_LAT  = 3;

   localparam logic [FLOAT_W-1:0] FLOAT_QNAN = 32'h7fc0_0000;
   localparam logic [7:0]         FLOAT_EXP_MAX = 8'hff;
   localparam logic [HALF_W-1:0]  HALF_INF = 16'h7c00;

   localparam logic [CODE_W-1:0] CODE_NEG_RE = 2'd0;
   localparam logic [CODE_W-1:0] CODE_POS_RE = 2'd1;
   localparam logic [CODE_W-1:0] CODE_NEG_IM = 2'd2;
   localparam logic [CODE_W-1:0] CODE_POS_IM = 2'd3;

   typedef struct packed {
      logic       nan;
      logic       inf;
      logic       inf_sign;
      logic       sign;
      logic       sub;
      logic       zero_sign;
      logic [7:0] exp;
   } add_ctl_type;

endpackage

// ===== rtl/pcf_fadd.sv =====
// three stage single precision adder, round to nearest even
module pcf_fadd import pcf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [FLOAT_W-1:0] a,
   input  logic [FLOAT_W-1:0] b,
   output logic               out_valid,
   output logic [FLOAT_W-1:0] sum
);

   logic              v1_ff, v2_ff, v3_ff;
   add_ctl_type       c1_in, c1_ff, c2_ff;
   logic [26:0]       big_in, big_ff, small_in, small_ff;
   logic [27:0]       sum_in, sum_ff;
   logic [4:0]        lz_in, lz_ff;
   logic [FLOAT_W-1:0] res_in, res_ff;

   // stage 1: classify, swap, align
   logic [7:0]  ea, eb, eab, ebb, d;
   logic        a_nan, b_nan, a_inf, b_inf, swap;
   logic [23:0] mbig, msml;
   logic [53:0] wide;

   always_comb begin
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      a_nan = (a[30:23] == FLOAT_EXP_MAX) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == FLOAT_EXP_MAX) && (b[22:0] != 23'd0);
      a_inf = (a[30:23] == FLOAT_EXP_MAX) && (a[22:0] == 23'd0);
      b_inf = (b[30:23] == FLOAT_EXP_MAX) && (b[22:0] == 23'd0);
      swap = b[30:0] > a[30:0];
      eab  = swap ? eb : ea;
      ebb  = swap ? ea : eb;
      mbig = swap ? {|b[30:23], b[22:0]} : {|a[30:23], a[22:0]};
      msml = swap ? {|a[30:23], a[22:0]} : {|b[30:23], b[22:0]};
      d = eab - ebb;
      wide = {msml, 3'b000, 27'd0} >> d[4:0];
      big_in = {mbig, 3'b000};
      if (d >= 8'd27) begin
         small_in = {26'd0, |msml};
      end else begin
         small_in = {wide[53:28], wide[27] | (|wide[26:0])};
      end
      c1_in.nan = a_nan || b_nan || (a_inf && b_inf && (a[31] ^ b[31]));
      c1_in.inf = a_inf || b_inf;
      c1_in.inf_sign = a_inf ? a[31] : b[31];
      c1_in.sign = swap ? b[31] : a[31];
      c1_in.sub = a[31] ^ b[31];
      c1_in.zero_sign = (a[31] ^ b[31]) ? 1'b0 : a[31];
      c1_in.exp = eab;
   end

   // stage 2: add and count leading zeros
   always_comb begin
      sum_in = c1_ff.sub ? ({1'b0, big_ff} - {1'b0, small_ff})
                         : ({1'b0, big_ff} + {1'b0, small_ff});
      lz_in = 5'd27;
      for (int i = 0; i <= 26; i++) begin
         if (sum_in[i]) begin
            lz_in = 5'(26 - i);
         end
      end
   end

   // stage 3: normalize and round
   logic [4:0]  shamt;
   logic [26:0] m;
   logic [8:0]  e9;
   logic [7:0]  ef;
   logic        rnd;

   always_comb begin
      shamt = 5'd0;
      if (sum_ff[27]) begin
         m  = {sum_ff[27:2], sum_ff[1] | sum_ff[0]};
         e9 = {1'b0, c2_ff.exp} + 9'd1;
      end else begin
         shamt = ({3'd0, lz_ff} < c2_ff.exp) ? lz_ff : 5'(c2_ff.exp - 8'd1);
         m  = sum_ff[26:0] << shamt;
         e9 = {1'b0, c2_ff.exp} - {4'd0, shamt};
      end
      ef  = m[26] ? e9[7:0] : 8'd0;
      rnd = m[2] & (m[1] | m[0] | m[3]);
      if (c2_ff.nan) begin
         res_in = FLOAT_QNAN;
      end else if (c2_ff.inf) begin
         res_in = {c2_ff.inf_sign, FLOAT_EXP_MAX, 23'd0};
      end else if (sum_ff == 28'd0) begin
         res_in = {c2_ff.zero_sign, 31'd0};
      end else if (e9 >= 9'd255) begin
         res_in = {c2_ff.sign, FLOAT_EXP_MAX, 23'd0};
      end else begin
         res_in = {c2_ff.sign, {ef, m[25:3]} + {30'd0, rnd}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff    <= c1_in;
         big_ff   <= big_in;
         small_ff <= small_in;
         c2_ff    <= c1_ff;
         sum_ff   <= sum_in;
         lz_ff    <= lz_in;
         res_ff   <= res_in;
      end
   end

   assign out_valid = v3_ff;
   assign sum       = res_ff;

endmodule

// ===== rtl/pcf_half.sv =====
// single to half conversion and result register
module pcf_half import pcf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [FLOAT_W-1:0] x0,
   input  logic [FLOAT_W-1:0] x1,
   input  logic [FLOAT_W-1:0] x2,
   input  logic [FLOAT_W-1:0] x3,
   output logic               out_valid,
   output logic [HALF_W-1:0]  h0,
   output logic [HALF_W-1:0]  h1,
   output logic [HALF_W-1:0]  h2,
   output logic [HALF_W-1:0]  h3
);

   function automatic logic [HALF_W-1:0] to_half(input logic [FLOAT_W-1:0] x);
      logic [7:0]  ex;
      logic [15:0] sg;
      logic [23:0] mm;
      logic [4:0]  sh;
      logic [23:0] hs;
      logic [23:0] rs;
      logic [7:0]  eh;
      logic [HALF_W-1:0] r;
      ex = x[30:23];
      sg = {x[31], 15'd0};
      mm = {1'b1, x[22:0]};
      sh = 5'(8'd126 - ex);
      hs = mm >> sh;
      rs = mm >> (sh - 5'd1);
      eh = ex - 8'd112;
      if (ex == FLOAT_EXP_MAX && x[22:0] != 23'd0) begin
         r = HALF_INF;
      end else if (ex < 8'd102) begin
         r = sg;
      end else if (ex <= 8'd112) begin
         r = sg | (hs[15:0] + {15'd0, rs[0]});
      end else if (ex >= 8'd143) begin
         r = sg | HALF_INF;
      end else begin
         r = {x[31], eh[4:0], x[22:13]} + {15'd0, x[12]};
      end
      return r;
   endfunction

   logic              v_ff;
   logic [HALF_W-1:0] h0_ff, h1_ff, h2_ff, h3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h0_ff <= to_half(x0);
         h1_ff <= to_half(x1);
         h2_ff <= to_half(x2);
         h3_ff <= to_half(x3);
      end
   end

   assign out_valid = v_ff;
   assign h0 = h0_ff;
   assign h1 = h1_ff;
   assign h2 = h2_ff;
   assign h3 = h3_ff;

endmodule

// ===== rtl/phase_code_coefficient_fuse.sv =====
// top level: weight selection, three adder levels, half conversion
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    four codes, eight single scales
//  rsp      out        rsp_valid/rsp_ready    four half coefficients
//
// one item per cycle while the result is not stalled; three levels of 3-stage adders plus the half stage
// the whole pipeline advances together when the result register is empty or taken
// a stalled result holds every stage; reset clears only the valid bits
module phase_code_coefficient_fuse import pcf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CODE_W-1:0]  req_code_a,
   input  logic [CODE_W-1:0]  req_code_b,
   input  logic [CODE_W-1:0]  req_code_c,
   input  logic [CODE_W-1:0]  req_code_d,
   input  logic [FLOAT_W-1:0] req_scale_a_re,
   input  logic [FLOAT_W-1:0] req_scale_a_im,
   input  logic [FLOAT_W-1:0] req_scale_b_re,
   input  logic [FLOAT_W-1:0] req_scale_b_im,
   input  logic [FLOAT_W-1:0] req_scale_c_re,
   input  logic [FLOAT_W-1:0] req_scale_c_im,
   input  logic [FLOAT_W-1:0] req_scale_d_re,
   input  logic [FLOAT_W-1:0] req_scale_d_im,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [HALF_W-1:0]  rsp_coef_re_from_re,
   output logic [HALF_W-1:0]  rsp_coef_re_from_im,
   output logic [HALF_W-1:0]  rsp_coef_im_from_re,
   output logic [HALF_W-1:0]  rsp_coef_im_from_im
);

   function automatic logic [FLOAT_W-1:0] neg(input logic [FLOAT_W-1:0] x);
      return {~x[31], x[30:0]};
   endfunction

   function automatic logic [2*FLOAT_W-1:0] pick(input logic [CODE_W-1:0] code,
                                                 input logic [FLOAT_W-1:0] re,
                                                 input logic [FLOAT_W-1:0] im);
      logic [2*FLOAT_W-1:0] w;
      w = '0;
      case (code)
         CODE_NEG_RE: w[2*FLOAT_W-1:FLOAT_W] = neg(re);
         CODE_POS_RE: w[2*FLOAT_W-1:FLOAT_W] = re;
         CODE_NEG_IM: w[FLOAT_W-1:0] = neg(im);
         CODE_POS_IM: w[FLOAT_W-1:0] = im;
         default:     w = '0;
      endcase
      return w;
   endfunction

   logic en;
   logic [2*FLOAT_W-1:0] wa, wb, wc, wd;
   logic [2*FLOAT_W-1:0] c_dly_ff [ADD_LAT];
   logic [2*FLOAT_W-1:0] d_dly_ff [2*ADD_LAT];
   logic [FLOAT_W-1:0] cr, ci, dr, di;
   logic v1, v2, v3;
   logic [FLOAT_W-1:0] p1, q1, r1, p2a, p2b, q2, r2, s0, s1, s2, s3;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   assign wa = pick(req_code_a, req_scale_a_re, req_scale_a_im);
   assign wb = pick(req_code_b, req_scale_b_re, req_scale_b_im);
   assign wc = pick(req_code_c, req_scale_c_re, req_scale_c_im);
   assign wd = pick(req_code_d, req_scale_d_re, req_scale_d_im);

   always_ff @(posedge clock) begin
      if (en) begin
         c_dly_ff[0] <= wc;
         for (int i = 1; i < ADD_LAT; i++) begin
            c_dly_ff[i] <= c_dly_ff[i-1];
         end
         d_dly_ff[0] <= wd;
         for (int i = 1; i < 2*ADD_LAT; i++) begin
            d_dly_ff[i] <= d_dly_ff[i-1];
         end
      end
   end

   assign cr = c_dly_ff[ADD_LAT-1][2*FLOAT_W-1:FLOAT_W];
   assign ci = c_dly_ff[ADD_LAT-1][FLOAT_W-1:0];
   assign dr = d_dly_ff[2*ADD_LAT-1][2*FLOAT_W-1:FLOAT_W];
   assign di = d_dly_ff[2*ADD_LAT-1][FLOAT_W-1:0];

   // level 1
   pcf_fadd u_p1 (.clock, .reset, .en, .in_valid(req_valid && en),
      .a(wa[2*FLOAT_W-1:FLOAT_W]), .b(wb[2*FLOAT_W-1:FLOAT_W]), .out_valid(v1), .sum(p1));
   pcf_fadd u_q1 (.clock, .reset, .en, .in_valid(req_valid && en),
      .a(neg(wa[FLOAT_W-1:0])), .b(neg(wb[FLOAT_W-1:0])), .out_valid(), .sum(q1));
   pcf_fadd u_r1 (.clock, .reset, .en, .in_valid(req_valid && en),
      .a(wa[FLOAT_W-1:0]), .b(wb[FLOAT_W-1:0]), .out_valid(), .sum(r1));

   // level 2
   pcf_fadd u_p2a (.clock, .reset, .en, .in_valid(v1),
      .a(p1), .b(cr), .out_valid(v2), .sum(p2a));
   pcf_fadd u_p2b (.clock, .reset, .en, .in_valid(v1),
      .a(p1), .b(neg(cr)), .out_valid(), .sum(p2b));
   pcf_fadd u_q2 (.clock, .reset, .en, .in_valid(v1),
      .a(q1), .b(ci), .out_valid(), .sum(q2));
   pcf_fadd u_r2 (.clock, .reset, .en, .in_valid(v1),
      .a(r1), .b(ci), .out_valid(), .sum(r2));

   // level 3
   pcf_fadd u_s0 (.clock, .reset, .en, .in_valid(v2),
      .a(p2a), .b(dr), .out_valid(v3), .sum(s0));
   pcf_fadd u_s1 (.clock, .reset, .en, .in_valid(v2),
      .a(q2), .b(di), .out_valid(), .sum(s1));
   pcf_fadd u_s2 (.clock, .reset, .en, .in_valid(v2),
      .a(r2), .b(di), .out_valid(), .sum(s2));
   pcf_fadd u_s3 (.clock, .reset, .en, .in_valid(v2),
      .a(p2b), .b(neg(dr)), .out_valid(), .sum(s3));

   pcf_half u_half (.clock, .reset, .en, .in_valid(v3),
      .x0(s0), .x1(s1), .x2(s2), .x3(s3), .out_valid(rsp_valid),
      .h0(rsp_coef_re_from_re), .h1(rsp_coef_re_from_im),
      .h2(rsp_coef_im_from_re), .h3(rsp_coef_im_from_im));

`ifndef ASSERT_OFF
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable({v1, v2, v3, rsp_valid}))
      else $error("pipeline moved during stall");

   a_no_half_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_coef_re_from_re[14:10] != 5'h1f || rsp_coef_re_from_re[9:0] == 10'd0) &&
         (rsp_coef_re_from_im[14:10] != 5'h1f || rsp_coef_re_from_im[9:0] == 10'd0) &&
         (rsp_coef_im_from_re[14:10] != 5'h1f || rsp_coef_im_from_re[9:0] == 10'd0) &&
         (rsp_coef_im_from_im[14:10] != 5'h1f || rsp_coef_im_from_im[9:0] == 10'd0))
      else $error("half result is a nan code");
`endif

endmodule

// ===== bench/pcf_checker.sv =====
// coefficient predictor and result checker for the phase code coefficient fuse
`timescale 1ns / 1ps
module pcf_checker import pcf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [CODE_W-1:0]  req_code_a,
   input  logic [CODE_W-1:0]  req_code_b,
   input  logic [CODE_W-1:0]  req_code_c,
   input  logic [CODE_W-1:0]  req_code_d,
   input  logic [FLOAT_W-1:0] req_scale_a_re,
   input  logic [FLOAT_W-1:0] req_scale_a_im,
   input  logic [FLOAT_W-1:0] req_scale_b_re,
   input  logic [FLOAT_W-1:0] req_scale_b_im,
   input  logic [FLOAT_W-1:0] req_scale_c_re,
   input  logic [FLOAT_W-1:0] req_scale_c_im,
   input  logic [FLOAT_W-1:0] req_scale_d_re,
   input  logic [FLOAT_W-1:0] req_scale_d_im,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [HALF_W-1:0]  rsp_coef_re_from_re,
   input  logic [HALF_W-1:0]  rsp_coef_re_from_im,
   input  logic [HALF_W-1:0]  rsp_coef_im_from_re,
   input  logic [HALF_W-1:0]  rsp_coef_im_from_im,
   output int                 fail_count,
   output int                 pending,
   output int                 checked
);

   typedef struct packed {
      logic [HALF_W-1:0] re_from_re;
      logic [HALF_W-1:0] re_from_im;
      logic [HALF_W-1:0] im_from_re;
      logic [HALF_W-1:0] im_from_im;
   } coef_set_type;

   coef_set_type coef_queue[$];

   function automatic real single_to_real(logic [FLOAT_W-1:0] b);
      real r;
      if (b[30:23] == 8'h00) begin
         r = $itor(b[22:0]) * (2.0 ** (-149));
         return b[31] ? -r : r;
      end
      if (b[30:23] == FLOAT_EXP_MAX) return $bitstoreal({b[31], 11'h7ff, b[22:0], 29'b0});
      return $bitstoreal({b[31], 11'(b[30:23] + 896), b[22:0], 29'b0});
   endfunction

   // round a double to single, nearest even, with subnormals
   function automatic logic [FLOAT_W-1:0] real_to_single(real r);
      logic [63:0] d, sig, q, rem, halfw;
      int e, sh;
      logic s;
      d = $realtobits(r);
      s = d[63];
      e = int'(d[62:52]);
      if (e == 2047) return (d[51:0] != 0) ? FLOAT_QNAN : {s, 31'h7f80_0000};
      if (e == 0) return {s, 31'h0};
      e = e - 1023;
      sig = {11'b0, 1'b1, d[51:0]};
      sh = (e >= -126) ? 29 : 29 + (-126 - e);
      if (sh > 54) return {s, 31'h0};
      q = sig >> sh;
      rem = sig & ((64'd1 << sh) - 64'd1);
      halfw = 64'd1 << (sh - 1);
      if (rem > halfw || (rem == halfw && q[0])) q = q + 64'd1;
      if (e >= -126) begin
         if (q[24]) begin
            e = e + 1;
            q = q >> 1;
         end
         if (e > 127) return {s, 31'h7f80_0000};
         return {s, 8'(e + 127), q[22:0]};
      end
      return {s, q[30:0]};
   endfunction

   function automatic logic [FLOAT_W-1:0] single_add(logic [FLOAT_W-1:0] a,
                                                     logic [FLOAT_W-1:0] b);
      return real_to_single(single_to_real(a) + single_to_real(b));
   endfunction

   function automatic logic [HALF_W-1:0] single_to_half(logic [FLOAT_W-1:0] b);
      logic [15:0] sgn;
      logic [31:0] mant, hv;
      int e, sh;
      sgn = {b[31], 15'b0};
      e = int'(b[30:23]) - 127 + 15;
      mant = {9'b0, b[22:0]};
      if (b[30:23] == FLOAT_EXP_MAX && mant != 0) return HALF_INF;
      if (e <= 0) begin
         if (e < -10) return sgn;
         mant = mant | 32'h0080_0000;
         sh = 14 - e;
         hv = mant >> sh;
         if (mant[sh-1]) hv = hv + 1;
         return sgn | hv[15:0];
      end
      if (e >= 31) return sgn | HALF_INF;
      hv = {16'b0, sgn} | (e << 10) | (mant >> 13);
      if (mant[12]) hv = hv + 1;
      return hv[15:0];
   endfunction

   function automatic void pick_weight(logic [CODE_W-1:0] code, logic [FLOAT_W-1:0] re,
                                       logic [FLOAT_W-1:0] im,
                                       output logic [FLOAT_W-1:0] wr,
                                       output logic [FLOAT_W-1:0] wi);
      wr = '0;
      wi = '0;
      case (code)
         CODE_NEG_RE: wr = {~re[31], re[30:0]};
         CODE_POS_RE: wr = re;
         CODE_NEG_IM: wi = {~im[31], im[30:0]};
         default: wi = im;
      endcase
   endfunction

   function automatic coef_set_type fuse_coefficients();
      logic [FLOAT_W-1:0] ar, ai, br, bi, cr, ci, dr, di, s, ab;
      coef_set_type c;
      pick_weight(req_code_a, req_scale_a_re, req_scale_a_im, ar, ai);
      pick_weight(req_code_b, req_scale_b_re, req_scale_b_im, br, bi);
      pick_weight(req_code_c, req_scale_c_re, req_scale_c_im, cr, ci);
      pick_weight(req_code_d, req_scale_d_re, req_scale_d_im, dr, di);
      ab = single_add(ar, br);
      s = single_add(single_add(ab, cr), dr);
      c.re_from_re = single_to_half(s);
      s = single_add({~ai[31], ai[30:0]}, {~bi[31], bi[30:0]});
      s = single_add(single_add(s, ci), di);
      c.re_from_im = single_to_half(s);
      s = single_add(single_add(single_add(ai, bi), ci), di);
      c.im_from_re = single_to_half(s);
      s = single_add(ab, {~cr[31], cr[30:0]});
      s = single_add(s, {~dr[31], dr[30:0]});
      c.im_from_im = single_to_half(s);
      return c;
   endfunction

   assign pending = coef_queue.size();

   always @(posedge clock) begin
      coef_set_type want, got;
      if (!reset && req_valid && req_ready) coef_queue.push_back(fuse_coefficients());
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_coef_re_from_re, rsp_coef_re_from_im, rsp_coef_im_from_re,
                rsp_coef_im_from_im};
         checked = checked + 1;
         if (coef_queue.size() == 0) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) $display("unexpected transfer on rsp: %h", got);
         end else begin
            want = coef_queue.pop_front();
            if (want != got) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10)
                  $display("mismatch rr/ri/ir/ii: expected %h %h %h %h, got %h %h %h %h",
                           want.re_from_re, want.re_from_im, want.im_from_re,
                           want.im_from_im, got.re_from_re, got.re_from_im,
                           got.im_from_re, got.im_from_im);
            end
         end
      end
   end

endmodule

// ===== bench/tb_phase_code_coefficient_fuse.sv =====
// stimulus and verdict for the phase code coefficient fuse
`timescale 1ns / 1ps
module tb_phase_code_coefficient_fuse import pcf_pkg::*;;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [CODE_W-1:0]  code [4] = '{default: '0};
   logic [FLOAT_W-1:0] scale [8] = '{default: '0};
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [HALF_W-1:0]  rr, ri, ir, ii;
   int                 fail_count, pending, checked;
   int                 cycle_count = 0;
   int                 sent = 0;
   bit                 calm = 1'b0;

   localparam int N_RANDOM = 1630;
   localparam int LIMIT    = 200000;

   always #2 clock = ~clock;

   phase_code_coefficient_fuse u_top (
      .clock, .reset, .req_valid, .req_ready,
      .req_code_a(code[0]), .req_code_b(code[1]), .req_code_c(code[2]),
      .req_code_d(code[3]),
      .req_scale_a_re(scale[0]), .req_scale_a_im(scale[1]),
      .req_scale_b_re(scale[2]), .req_scale_b_im(scale[3]),
      .req_scale_c_re(scale[4]), .req_scale_c_im(scale[5]),
      .req_scale_d_re(scale[6]), .req_scale_d_im(scale[7]),
      .rsp_valid, .rsp_ready,
      .rsp_coef_re_from_re(rr), .rsp_coef_re_from_im(ri),
      .rsp_coef_im_from_re(ir), .rsp_coef_im_from_im(ii)
   );

   pcf_checker u_checker (
      .clock, .reset, .req_valid, .req_ready,
      .req_code_a(code[0]), .req_code_b(code[1]), .req_code_c(code[2]),
      .req_code_d(code[3]),
      .req_scale_a_re(scale[0]), .req_scale_a_im(scale[1]),
      .req_scale_b_re(scale[2]), .req_scale_b_im(scale[3]),
      .req_scale_c_re(scale[4]), .req_scale_c_im(scale[5]),
      .req_scale_d_re(scale[6]), .req_scale_d_im(scale[7]),
      .rsp_valid, .rsp_ready,
      .rsp_coef_re_from_re(rr), .rsp_coef_re_from_im(ri),
      .rsp_coef_im_from_re(ir), .rsp_coef_im_from_im(ii),
      .fail_count, .pending, .checked
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[phase_code_coefficient_fuse] ERROR");
         $finish;
      end
   end

   always @(negedge clock) rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);

   // values mostly near the half range, with shared magnitudes so sums can cancel
   function automatic logic [FLOAT_W-1:0] near_half_value(logic [FLOAT_W-1:0] pool);
      case ($urandom_range(5))
         0: return $urandom;
         1: return pool;
         2: return {~pool[31], pool[30:0]};
         default: return {1'($urandom), 8'($urandom_range(100, 145)), 23'($urandom)};
      endcase
   endfunction

   // one transfer on req; payload set at the falling edge
   task automatic send_item(logic [CODE_W-1:0] c [4], logic [FLOAT_W-1:0] s [8]);
      while (!calm && $urandom_range(99) < 33) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      code = c;
      scale = s;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      sent = sent + 1;
      @(negedge clock);
   endtask

   initial begin
      logic [FLOAT_W-1:0] corner [12];
      logic [CODE_W-1:0]  c [4];
      logic [FLOAT_W-1:0] s [8];
      logic [FLOAT_W-1:0] pool;
      corner = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
                 32'h7fc0_0000, 32'h7f7f_ffff, 32'h0000_0001, 32'h477f_e000,
                 32'h477f_f000, 32'h3300_0000, 32'h387f_f000, 32'h3f80_1000};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int k = 0; k < 20; k++) begin
         foreach (c[i]) c[i] = CODE_W'((k + i) % 4);
         foreach (s[i]) s[i] = corner[(k + 3 * i) % 12];
         if (k >= 16) foreach (s[i]) s[i] = corner[k - 8];
         send_item(c, s);
      end
      for (int k = 0; k < N_RANDOM; k++) begin
         calm = (k >= 600 && k < 900);
         pool = {1'($urandom), 8'($urandom_range(100, 145)), 23'($urandom)};
         foreach (c[i]) c[i] = CODE_W'($urandom);
         foreach (s[i]) s[i] = ($urandom_range(3) == 0) ? $urandom : near_half_value(pool);
         send_item(c, s);
      end
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("sent %0d items through all code mixes and float corners, %0d results checked",
               sent, checked);
      if (fail_count == 0) begin
         $display("[phase_code_coefficient_fuse] OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("[phase_code_coefficient_fuse] ERROR");
      end
      $finish;
   end

endmodule
